FILE: design/multi_queue_mailbox_engine_core_assert.svh
// Assertion macros for the mailbox engine; clk and rst_n are taken from the
// scope where a macro is used.
`ifndef MULTI_QUEUE_MAILBOX_ENGINE_CORE_ASSERT_SVH
`define MULTI_QUEUE_MAILBOX_ENGINE_CORE_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define MQME_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("mailbox engine check failed");

// Check a consequent in the cycle after its antecedent.
`define MQME_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("mailbox engine check failed");

`endif

FILE: design/mqme_pkg.sv
package mqme_pkg;

  // Width used for small index and count arithmetic
  localparam int CALC_W = 8;

  // Request codes
  localparam logic [2:0] OP_SEND  = 3'd0;
  localparam logic [2:0] OP_FORCE = 3'd1;
  localparam logic [2:0] OP_RECV  = 3'd2;
  localparam logic [2:0] OP_PEEK  = 3'd3;
  localparam logic [2:0] OP_QUERY = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_QUEUES_IN_USE  = 2'd0;
  localparam logic [1:0] CFG_QUEUE_CAPACITY = 2'd1;
  localparam logic [1:0] CFG_ELEMENT_BYTES  = 2'd2;

  // Configuration reset values
  localparam logic [3:0] QUEUES_IN_USE_RST  = 4'd8;
  localparam logic [4:0] QUEUE_CAPACITY_RST = 5'd16;
  localparam logic [3:0] ELEMENT_BYTES_RST  = 4'd8;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [1:0]  bus_number;
    logic [3:0]  queue_number;
    logic [63:0] element_data;
    logic [7:0]  size_bytes;
  } mqme_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_data;
    logic        arrived;
  } mqme_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;
    logic eval;
  } mqme_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_RESP
  } mqme_state_t;

endpackage

FILE: design/multi_queue_mailbox_engine_core.sv
// A result strobes on out_valid in S_RESP, after S_IDLE takes an item and S_EVAL evaluates it.
// Items do not overlap: the counter memory read, the evaluate and store access, and
// the result strobe run in turn, and busy is high from the accept on.
// The receiver cannot stall: each result is shown for one cycle only.
// Reset (synchronous, rst_n low) empties every queue and restores the configuration
// defaults at once; element storage is not cleared.
module multi_queue_mailbox_engine_core
  import mqme_pkg::*;
#(
  parameter int NUM_BUSES      = 2,
  parameter int QUEUES_PER_BUS = 8,
  parameter int MAX_DEPTH      = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  mqme_in_t   in_data,
  output logic       out_valid,
  output mqme_out_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [4:0] cfg_wdata
);

  mqme_cmd_t cmd;

  mqme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  mqme_dp #(
    .NUM_BUSES      (NUM_BUSES),
    .QUEUES_PER_BUS (QUEUES_PER_BUS),
    .MAX_DEPTH      (MAX_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

  `include "multi_queue_mailbox_engine_core_assert.svh"

  // An accepted item is always followed by its result strobe
  `MQME_ASSERT_NOW(a_item_result, start && !busy, ##2 out_valid)
  // Results never come back to back
  `MQME_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  // Only a successful receive or peek returns data
  `MQME_ASSERT_NOW(a_data_only_ok, out_valid && (out_data.status != ST_OK), out_data.read_data == '0)
  // An arrival flag comes only with an ok status and no data
  `MQME_ASSERT_NOW(a_arrived_ok, out_valid && out_data.arrived, (out_data.status == ST_OK) && (out_data.read_data == '0))

endmodule

FILE: design/mqme_ctrl.sv
module mqme_ctrl
  import mqme_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output logic      out_valid,
  output mqme_cmd_t cmd
);

  mqme_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence one item: latch and fetch queue state, evaluate, present result
  always_comb begin
    state_nxt = state_r;
    cmd.latch = 1'b0;
    cmd.eval  = 1'b0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/mqme_dp.sv
module mqme_dp
  import mqme_pkg::*;
#(
  parameter int NUM_BUSES      = 2,
  parameter int QUEUES_PER_BUS = 8,
  parameter int MAX_DEPTH      = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  mqme_cmd_t  cmd,
  input  mqme_in_t   in_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [4:0] cfg_wdata,
  output mqme_out_t  out_data
);

  localparam int QC  = NUM_BUSES * QUEUES_PER_BUS;
  localparam int QIW = (QC > 1) ? $clog2(QC) : 1;
  localparam int PW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int FW  = $clog2(MAX_DEPTH + 1);
  localparam int SD  = QC * MAX_DEPTH;
  localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
  localparam int MW  = FW + 2 * PW;

  // Step a ring position, wrapping once it reaches the capacity
  function automatic logic [CALC_W-1:0] adv_pos(input logic [CALC_W-1:0] pos,
                                                input logic [CALC_W-1:0] cap);
    logic [CALC_W-1:0] inc;
    inc = pos + 1'b1;
    return (inc >= cap) ? '0 : inc;
  endfunction

  // Configuration registers
  logic [3:0] qiu_r;
  logic [4:0] qcap_r;
  logic [3:0] ebytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qiu_r    <= QUEUES_IN_USE_RST;
      qcap_r   <= QUEUE_CAPACITY_RST;
      ebytes_r <= ELEMENT_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_QUEUES_IN_USE:  qiu_r    <= cfg_wdata[3:0];
        CFG_QUEUE_CAPACITY: qcap_r   <= cfg_wdata;
        CFG_ELEMENT_BYTES:  ebytes_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Address check and queue index of the incoming item
  logic              addr_ok_in;
  logic [CALC_W-1:0] bus_ext, q_ext, qi_full;
  logic [QIW-1:0]    qi_in;

  assign bus_ext    = {{(CALC_W-2){1'b0}}, in_data.bus_number};
  assign q_ext      = {{(CALC_W-4){1'b0}}, in_data.queue_number};
  assign addr_ok_in = (bus_ext < CALC_W'(NUM_BUSES)) &&
                      (in_data.queue_number < qiu_r) &&
                      (q_ext < CALC_W'(QUEUES_PER_BUS));
  assign qi_full    = bus_ext * CALC_W'(QUEUES_PER_BUS) + q_ext;
  assign qi_in      = addr_ok_in ? qi_full[QIW-1:0] : '0;

  // Request registers
  mqme_in_t       req_r;
  logic           addr_ok_r;
  logic [QIW-1:0] qi_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r     <= in_data;
      addr_ok_r <= addr_ok_in;
      qi_r      <= qi_in;
    end
  end

  // Per-queue counters: one memory word per queue plus a valid bit
  logic [MW-1:0] meta_mem [QC];
  logic [MW-1:0] meta_q_r;
  logic          mvld_q_r;
  logic [QC-1:0] meta_vld_r;
  logic          meta_we;
  logic [FW-1:0] fill_n;
  logic [PW-1:0] wp_n, rp_n;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      meta_q_r <= meta_mem[qi_in];
    end
    if (cmd.eval && meta_we) begin
      meta_mem[qi_r] <= {fill_n, wp_n, rp_n};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_vld_r <= '0;
      mvld_q_r   <= 1'b0;
    end else begin
      if (cmd.latch) begin
        mvld_q_r <= meta_vld_r[qi_in];
      end
      if (cmd.eval && meta_we) begin
        meta_vld_r[qi_r] <= 1'b1;
      end
    end
  end

  // Unpack counters, a queue never written reads as empty
  logic [FW-1:0]     fill_c;
  logic [PW-1:0]     wp_c, rp_c;
  logic [CALC_W-1:0] fill_e, wp_e, rp_e, cap_c, qcap_e;
  logic [CALC_W-1:0] fill_inc, fill_dec, wp_adv, rp_adv;

  assign fill_c = mvld_q_r ? meta_q_r[MW-1 -: FW] : '0;
  assign wp_c   = mvld_q_r ? meta_q_r[2*PW-1 -: PW] : '0;
  assign rp_c   = mvld_q_r ? meta_q_r[PW-1:0] : '0;

  assign fill_e = {{(CALC_W-FW){1'b0}}, fill_c};
  assign wp_e   = {{(CALC_W-PW){1'b0}}, wp_c};
  assign rp_e   = {{(CALC_W-PW){1'b0}}, rp_c};

  // Saturate capacity at the ring depth
  assign qcap_e = {{(CALC_W-5){1'b0}}, qcap_r};
  assign cap_c  = (qcap_e > CALC_W'(MAX_DEPTH)) ? CALC_W'(MAX_DEPTH) : qcap_e;

  assign fill_inc = fill_e + 1'b1;
  assign fill_dec = fill_e - 1'b1;
  assign wp_adv   = adv_pos(wp_e, cap_c);
  assign rp_adv   = adv_pos(rp_e, cap_c);

  // Keep only the configured number of low bytes
  logic [63:0] elem_mask;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      elem_mask[8*i +: 8] = (ebytes_r > 4'(i)) ? 8'hFF : 8'h00;
    end
  end

  // Decide the outcome of the item
  logic          size_ok;
  logic [1:0]    status_c;
  logic          arrived_c;
  logic          st_we, st_re;
  logic [PW-1:0] st_pos;

  assign size_ok = (req_r.size_bytes == {4'b0000, ebytes_r});

  always_comb begin
    status_c  = ST_INVALID;
    arrived_c = 1'b0;
    st_we     = 1'b0;
    st_re     = 1'b0;
    st_pos    = wp_c;
    meta_we   = 1'b0;
    fill_n    = fill_c;
    wp_n      = wp_c;
    rp_n      = rp_c;
    if (addr_ok_r) begin
      case (req_r.opcode)
        OP_QUERY: begin
          status_c  = ST_OK;
          arrived_c = (fill_c != '0);
        end
        OP_SEND: begin
          if (size_ok) begin
            if (fill_e >= cap_c) begin
              status_c = ST_FULL;
            end else begin
              status_c = ST_OK;
              st_we    = 1'b1;
              meta_we  = 1'b1;
              fill_n   = fill_inc[FW-1:0];
              wp_n     = wp_adv[PW-1:0];
            end
          end
        end
        OP_FORCE: begin
          if (size_ok) begin
            status_c = ST_OK;
            st_we    = 1'b1;
            st_pos   = '0;
            meta_we  = 1'b1;
            fill_n   = FW'(1);
            wp_n     = (cap_c <= CALC_W'(1)) ? '0 : PW'(1);
            rp_n     = '0;
          end
        end
        OP_RECV, OP_PEEK: begin
          if (size_ok) begin
            if (fill_c == '0) begin
              status_c = ST_EMPTY;
            end else begin
              status_c = ST_OK;
              st_re    = 1'b1;
              st_pos   = rp_c;
              if (req_r.opcode == OP_RECV) begin
                meta_we = 1'b1;
                fill_n  = fill_dec[FW-1:0];
                rp_n    = rp_adv[PW-1:0];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Element store, one ring of MAX_DEPTH entries per queue
  logic [63:0]    store_mem [SD];
  logic [63:0]    store_q_r;
  logic [SAW-1:0] st_addr;

  assign st_addr = SAW'(qi_r) * SAW'(MAX_DEPTH) + SAW'(st_pos);

  always_ff @(posedge clk) begin
    if (cmd.eval && st_we) begin
      store_mem[st_addr] <= req_r.element_data & elem_mask;
    end
    if (cmd.eval && st_re) begin
      store_q_r <= store_mem[st_addr];
    end
  end

  // Result registers
  logic [1:0] status_r;
  logic       arrived_r;
  logic       rd_sel_r;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      status_r  <= status_c;
      arrived_r <= arrived_c;
      rd_sel_r  <= st_re;
    end
  end

  assign out_data.status    = status_r;
  assign out_data.read_data = rd_sel_r ? store_q_r : '0;
  assign out_data.arrived   = arrived_r;

endmodule
